### rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/bdq_pkg.sv
// ============================================================================
// Bounded deque package
// Shared constants, request and status codes, and the sequencer state type.
// ============================================================================
package bdq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REM_VALUE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH,
        S_SHIFT
    } state_t;

endpackage

### rtl/core/bdq_store.sv
// ============================================================================
// Deque entry store
// Ring storage with one write port and one registered read port.
// ============================================================================
module bdq_store
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic signed [VALUE_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic signed [VALUE_W-1:0] rdata
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bounded_deque_with_delete_top.sv
// ============================================================================
// Bounded deque with delete by value
// Ring-buffered double-ended queue of signed 32-bit words with a sequencer.
// ============================================================================
// Inserts, clear and rejected requests finish in S_EXEC; removal at either
// end reads the entry in S_READ first, and removal by value walks the held
// entries in S_SEARCH and S_SHIFT, paced by the single store read port walking
// the ring one entry per cycle. A new word is taken in the cycle that done is
// high. The receiver cannot stall done. Reset clears the control state and
// the pointers; the entry store is not cleared and needs no pass.
// ============================================================================
module bounded_deque_with_delete_top
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  removed_value,
    output logic [COUNT_W-1:0]         entry_count
);

    // Ring pointers need log2(DEPTH) bits; the count must also hold DEPTH itself.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    // Sequencer state and the latched request.
    state_t                      state_reg, state_next;
    logic [MODE_W-1:0]           mode_reg, mode_next;
    logic signed [VALUE_W-1:0]   value_reg, value_next;

    // Architectural queue state: front slot and number of held entries.
    logic [PTR_W-1:0]            front_reg, front_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    // Walk position during search and shift: cur_reg is the ring slot of
    // the entry at offset off_reg from the front.
    logic [PTR_W-1:0]            cur_reg, cur_next;
    logic [CNT_W-1:0]            off_reg, off_next;

    // Result registers.
    logic                        done_reg, done_next;
    logic [STATUS_W-1:0]         status_reg, status_next;
    logic signed [VALUE_W-1:0]   removed_reg, removed_next;

    // Store port signals.
    logic                        st_we;
    logic [PTR_W-1:0]            st_waddr;
    logic signed [VALUE_W-1:0]   st_wdata;
    logic [PTR_W-1:0]            st_raddr;
    logic signed [VALUE_W-1:0]   st_rdata;

    logic                        is_full;
    logic                        is_empty;
    logic                        walk_last;
    logic [PTR_W-1:0]            tail_slot;
    logic [CNT_W+COUNT_W-1:0]    count_wide;

    // Slot of the entry at a given offset from the front. The sum stays
    // below twice the depth, so one conditional subtract wraps it.
    function automatic logic [PTR_W-1:0] ring_add(
        input logic [PTR_W-1:0] base,
        input logic [CNT_W-1:0] offs
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_SLOT : PTR_W'(p - PTR_W'(1));
    endfunction

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign walk_last = (CNT_W'(off_reg + CNT_W'(1)) == count_reg);

    // Back end slot: the entry past the last one for an insert, the last
    // entry itself for a removal.
    assign tail_slot = ring_add(front_reg,
                                (mode_reg == MODE_REM_BACK) ?
                                CNT_W'(count_reg - CNT_W'(1)) : count_reg);

    bdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Sequencer: S_EXEC decodes the request and either finishes it there, starts
    // a single store read, or starts a walk over the ring that first compares and
    // then moves each later entry one place toward the front.
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        value_next   = value_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        off_next     = off_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        removed_next = removed_reg;
        st_we        = 1'b0;
        st_waddr     = cur_reg;
        st_wdata     = value_reg;
        st_raddr     = ring_inc(cur_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    value_next = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Default outcome: a finished request with nothing removed.
                done_next    = 1'b1;
                status_next  = ST_OK;
                removed_next = '0;
                state_next   = S_IDLE;
                case (mode_reg)
                    MODE_INS_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            st_we      = 1'b1;
                            st_waddr   = ring_dec(front_reg);
                            front_next = ring_dec(front_reg);
                            count_next = CNT_W'(count_reg + CNT_W'(1));
                        end
                    end

                    MODE_INS_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            st_we      = 1'b1;
                            st_waddr   = tail_slot;
                            count_next = CNT_W'(count_reg + CNT_W'(1));
                        end
                    end

                    MODE_REM_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            st_raddr   = front_reg;
                            done_next  = 1'b0;
                            state_next = S_READ;
                        end
                    end

                    MODE_REM_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            st_raddr   = tail_slot;
                            done_next  = 1'b0;
                            state_next = S_READ;
                        end
                    end

                    MODE_REM_VALUE:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            st_raddr   = front_reg;
                            cur_next   = front_reg;
                            off_next   = '0;
                            done_next  = 1'b0;
                            state_next = S_SEARCH;
                        end
                    end

                    MODE_CLEAR:
                    begin
                        count_next = '0;
                        front_next = '0;
                    end

                    default:
                    begin
                        // Unused request codes leave the queue unchanged and finish with ST_OK.
                    end
                endcase
            end

            S_READ:
            begin
                removed_next = st_rdata;
                count_next   = CNT_W'(count_reg - CNT_W'(1));
                if (mode_reg == MODE_REM_FRONT)
                begin
                    front_next = ring_inc(front_reg);
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_SEARCH:
            begin
                // Read data holds the entry at off_reg; the next entry is
                // being read ahead through the default read address.
                if (st_rdata == value_reg)
                begin
                    removed_next = st_rdata;
                    state_next   = S_SHIFT;
                end
                else if (walk_last)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_NOTFOUND;
                    removed_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cur_next = ring_inc(cur_reg);
                    off_next = CNT_W'(off_reg + CNT_W'(1));
                end
            end

            S_SHIFT:
            begin
                // Read data holds the entry at off_reg + 1, which moves into
                // the slot at off_reg while the one after it is read.
                if (walk_last)
                begin
                    count_next  = CNT_W'(count_reg - CNT_W'(1));
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_waddr = cur_reg;
                    st_wdata = st_rdata;
                    st_raddr = ring_inc(ring_inc(cur_reg));
                    cur_next = ring_inc(cur_reg);
                    off_next = CNT_W'(off_reg + CNT_W'(1));
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload and walk registers need no reset.
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        value_reg   <= value_next;
        cur_reg     <= cur_next;
        off_reg     <= off_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // The count is reported in a fixed 7-bit field; it is widened first so
    // the low bits can be taken at any depth.
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = count_wide[COUNT_W-1:0];

endmodule

### rtl/core/bdq_checker.sv
// ============================================================================
// Deque port checker
// Watches the top level ports for sequencing and result consistency.
// ============================================================================
`include "assert_macros.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [STATUS_W-1:0]        status,
    input logic signed [VALUE_W-1:0]  removed_value,
    input logic [COUNT_W-1:0]         entry_count
);

    logic accept;
    logic rejected;

    assign accept   = start && !busy;
    assign rejected = done && (status == ST_FULL || status == ST_NOTFOUND);

    // An accepted word always makes the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)

    // The block only leaves the busy phase by delivering its result.
    `ASSERT_IMPLY(a_fall_done, clk, rst_n, $fell(busy), done)

    // Results never come in back-to-back cycles.
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // A request rejected as full or not found removes nothing.
    `ASSERT_IMPLY(a_reject_zero, clk, rst_n, rejected, removed_value == '0)

    // A removal reported as empty leaves the count at zero.
    `ASSERT_IMPLY(a_empty_count, clk, rst_n, done && (status == ST_EMPTY), entry_count == '0)

endmodule

bind bounded_deque_with_delete_top bdq_checker u_bdq_checker (.*);
